[rtl/css_pkg.sv]
package css_pkg;

    typedef struct packed {
        logic start_button;
        logic cradle_sensor;
        logic piece_sensor;
    } css_in_t;

    typedef struct packed {
        logic        step_pulse;
        logic        driver_disable;
        logic        stamp_out;
        logic [15:0] piece_count;
        logic [2:0]  display_status;
    } css_out_t;

    typedef struct packed {
        logic [7:0]  step_half_ticks;
        logic [9:0]  stamp_pulse_ticks;
        logic [12:0] stamp_settle_ticks;
        logic [12:0] announce_ticks;
        logic [3:0]  extra_steps;
    } css_cfg_t;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_HALF    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAMP_PULSE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAMP_SETTLE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ANNOUNCE     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXTRA_STEPS  = 3'd4;

    localparam logic [7:0]  RST_STEP_HALF    = 8'd2;
    localparam logic [9:0]  RST_STAMP_PULSE  = 10'd100;
    localparam logic [12:0] RST_STAMP_SETTLE = 13'd1100;
    localparam logic [12:0] RST_ANNOUNCE     = 13'd6000;
    localparam logic [3:0]  RST_EXTRA_STEPS  = 4'd3;

    localparam logic [2:0] STATUS_PROMPT   = 3'd0;
    localparam logic [2:0] STATUS_STARTING = 3'd1;
    localparam logic [2:0] STATUS_LOCKED   = 3'd2;
    localparam logic [2:0] STATUS_AUTO     = 3'd3;
    localparam logic [2:0] STATUS_COUNT    = 3'd4;

    localparam logic [3:0] STAMPS_WITH_PIECE = 4'd2;
    localparam logic [3:0] STAMPS_NO_PIECE   = 4'd4;
    localparam int         LAST_LOW_TICKS    = 10;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_ANNOUNCE  = 4'd1,
        PH_SEEK_HI   = 4'd2,
        PH_SEEK_LO   = 4'd3,
        PH_PASS_HI   = 4'd4,
        PH_PASS_LO   = 4'd5,
        PH_STAMP_ON  = 4'd6,
        PH_STAMP_OFF = 4'd7,
        PH_SETTLE    = 4'd8,
        PH_LEAVE_HI  = 4'd9,
        PH_LEAVE_LO  = 4'd10,
        PH_EXTRA_HI  = 4'd11,
        PH_EXTRA_LO  = 4'd12
    } css_phase_t;

endpackage

[rtl/conveyor_stamp_sequencer_top.sv]
// Channel  | Handshake                  | Payload
// item     | item_valid / item_ready    | item: start, cradle and piece sensor levels
// result   | result_valid / result_ready| result: step, disable, stamp, count, status
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item is taken per clock while the result side is not stalled; each item passes from the input
// register into the result register, where it is held until it is taken at a later edge.
// The sequencer state advances by one tick when the input register hands its item on.
// A stalled result holds both stages; item_ready drops only when both are full.
// Reset loads the register defaults and puts the sequencer at the idle prompt.
module conveyor_stamp_sequencer_top #(
    parameter int COUNT_BITS = 16,
    parameter int TIMER_BITS = 13
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  css_pkg::css_in_t                      item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output css_pkg::css_out_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [css_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [css_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import css_pkg::*;

    css_cfg_t cfg;
    css_in_t  item_reg;
    logic     item_valid_reg;
    css_out_t result_reg;
    logic     result_valid_reg;
    css_out_t tick_result;
    logic     advance;

    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    css_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    css_ctrl #(
        .COUNT_BITS (COUNT_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (tick_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= tick_result;
        end
    end

endmodule

[rtl/css_cfg.sv]
module css_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [css_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [css_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output css_pkg::css_cfg_t                     cfg
);
    import css_pkg::*;

    css_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_half_ticks    <= RST_STEP_HALF;
            cfg_reg.stamp_pulse_ticks  <= RST_STAMP_PULSE;
            cfg_reg.stamp_settle_ticks <= RST_STAMP_SETTLE;
            cfg_reg.announce_ticks     <= RST_ANNOUNCE;
            cfg_reg.extra_steps        <= RST_EXTRA_STEPS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_STEP_HALF:    cfg_reg.step_half_ticks    <= cfg_data[7:0];
                REG_STAMP_PULSE:  cfg_reg.stamp_pulse_ticks  <= cfg_data[9:0];
                REG_STAMP_SETTLE: cfg_reg.stamp_settle_ticks <= cfg_data[12:0];
                REG_ANNOUNCE:     cfg_reg.announce_ticks     <= cfg_data[12:0];
                REG_EXTRA_STEPS:  cfg_reg.extra_steps        <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

endmodule

[rtl/css_ctrl.sv]
module css_ctrl #(
    parameter int COUNT_BITS = 16,
    parameter int TIMER_BITS = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  css_pkg::css_in_t    item,
    input  css_pkg::css_cfg_t   cfg,
    output css_pkg::css_out_t   result
);
    import css_pkg::*;

    css_phase_t            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic                  armed_reg, armed_next;
    logic                  arms_reg, arms_next;
    logic                  latched_reg, latched_next;
    logic [3:0]            pulses_reg, pulses_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [2:0]            shown_reg, shown_next;
    logic                  drive_off_reg, drive_off_next;
    logic                  piece_reg, piece_next;

    logic [TIMER_BITS-1:0] step_len;
    logic [TIMER_BITS-1:0] pulse_len;
    logic [TIMER_BITS-1:0] settle_len;
    logic [TIMER_BITS-1:0] announce_len;
    logic [TIMER_BITS-1:0] timer_dec;
    logic                  timer_done;

    // An interval programmed as zero still lasts one tick.
    function automatic logic [TIMER_BITS-1:0] min_one(input logic [TIMER_BITS-1:0] len);
        min_one = (len == '0) ? TIMER_BITS'(1) : len;
    endfunction

    assign step_len     = min_one(TIMER_BITS'(cfg.step_half_ticks));
    assign pulse_len    = min_one(TIMER_BITS'(cfg.stamp_pulse_ticks));
    assign settle_len   = min_one(TIMER_BITS'(cfg.stamp_settle_ticks));
    assign announce_len = min_one(TIMER_BITS'(cfg.announce_ticks));
    assign timer_dec    = (timer_reg != '0) ? timer_reg - TIMER_BITS'(1) : '0;
    assign timer_done   = (timer_dec == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            armed_reg     <= 1'b0;
            arms_reg      <= 1'b1;
            latched_reg   <= 1'b0;
            pulses_reg    <= '0;
            total_reg     <= '0;
            shown_reg     <= STATUS_PROMPT;
            drive_off_reg <= 1'b1;
            piece_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            armed_reg     <= armed_next;
            arms_reg      <= arms_next;
            latched_reg   <= latched_next;
            pulses_reg    <= pulses_next;
            total_reg     <= total_next;
            shown_reg     <= shown_next;
            drive_off_reg <= drive_off_next;
            piece_reg     <= piece_next;
        end
    end

    // The tick is resolved in order: phase work, then the start of a work
    // cycle, then the start of stamping, then an abort, then an idle tick.
    always_comb
    begin
        logic go_top;
        logic go_stamp;
        logic go_abort;
        logic go_idle;

        go_top         = 1'b0;
        go_stamp       = 1'b0;
        go_abort       = 1'b0;
        go_idle        = 1'b0;
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        armed_next     = armed_reg;
        arms_next      = arms_reg;
        latched_next   = latched_reg;
        pulses_next    = pulses_reg;
        total_next     = total_reg;
        shown_next     = shown_reg;
        drive_off_next = drive_off_reg;
        piece_next     = piece_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                go_idle = 1'b1;
            end
            PH_ANNOUNCE:
            begin
                timer_next = timer_dec;
                if (timer_done)
                begin
                    if (armed_reg)
                    begin
                        shown_next = STATUS_AUTO;
                        go_top     = 1'b1;
                    end
                    else
                    begin
                        go_idle = 1'b1;
                    end
                end
            end
            PH_SEEK_HI, PH_PASS_HI, PH_LEAVE_HI:
            begin
                if (item.start_button)
                begin
                    go_abort = 1'b1;
                end
                else
                begin
                    timer_next = timer_dec;
                    if (timer_done)
                    begin
                        phase_next = css_phase_t'(phase_reg + 4'd1);
                        timer_next = step_len;
                    end
                end
            end
            PH_SEEK_LO:
            begin
                if (item.start_button)
                begin
                    go_abort = 1'b1;
                end
                else
                begin
                    timer_next = timer_dec;
                    if (timer_done)
                    begin
                        latched_next = item.cradle_sensor;
                        phase_next   = item.cradle_sensor ? PH_PASS_HI : PH_SEEK_HI;
                        timer_next   = step_len;
                    end
                end
            end
            PH_PASS_LO:
            begin
                if (item.start_button)
                begin
                    go_abort = 1'b1;
                end
                else
                begin
                    timer_next = timer_dec;
                    if (timer_done)
                    begin
                        latched_next = item.cradle_sensor;
                        if (item.cradle_sensor)
                        begin
                            phase_next = PH_PASS_HI;
                            timer_next = step_len;
                        end
                        else
                        begin
                            go_stamp = 1'b1;
                        end
                    end
                end
            end
            PH_STAMP_ON:
            begin
                timer_next = timer_dec;
                if (timer_done)
                begin
                    phase_next = PH_STAMP_OFF;
                    timer_next = pulse_len;
                end
            end
            PH_STAMP_OFF:
            begin
                timer_next = timer_dec;
                if (timer_done)
                begin
                    pulses_next = pulses_reg - 4'd1;
                    if (!pulses_next[0])
                    begin
                        phase_next = PH_SETTLE;
                        timer_next = settle_len;
                    end
                    else
                    begin
                        phase_next = PH_STAMP_ON;
                        timer_next = pulse_len;
                    end
                end
            end
            PH_SETTLE:
            begin
                timer_next = timer_dec;
                if (timer_done)
                begin
                    if (pulses_reg != 4'd0)
                    begin
                        phase_next = PH_STAMP_ON;
                        timer_next = pulse_len;
                    end
                    else
                    begin
                        if (piece_reg)
                        begin
                            total_next     = total_reg + COUNT_BITS'(1);
                            shown_next     = STATUS_COUNT;
                            drive_off_next = 1'b1;
                        end
                        if (item.start_button)
                        begin
                            go_abort = 1'b1;
                        end
                        else if (latched_reg)
                        begin
                            drive_off_next = 1'b0;
                            phase_next     = PH_LEAVE_HI;
                            timer_next     = step_len;
                        end
                        else
                        begin
                            go_top = 1'b1;
                        end
                    end
                end
            end
            PH_LEAVE_LO:
            begin
                if (item.start_button)
                begin
                    go_abort = 1'b1;
                end
                else
                begin
                    timer_next = timer_dec;
                    if (timer_done)
                    begin
                        latched_next = item.cradle_sensor;
                        if (item.cradle_sensor)
                        begin
                            phase_next = PH_LEAVE_HI;
                            timer_next = step_len;
                        end
                        else if (cfg.extra_steps == 4'd0)
                        begin
                            go_top = 1'b1;
                        end
                        else
                        begin
                            pulses_next = cfg.extra_steps;
                            phase_next  = PH_EXTRA_HI;
                            timer_next  = step_len;
                        end
                    end
                end
            end
            PH_EXTRA_HI:
            begin
                if (item.start_button)
                begin
                    go_abort = 1'b1;
                end
                else
                begin
                    timer_next = timer_dec;
                    if (timer_done)
                    begin
                        phase_next = PH_EXTRA_LO;
                        timer_next = (pulses_reg <= 4'd1) ? TIMER_BITS'(LAST_LOW_TICKS)
                                                          : step_len;
                    end
                end
            end
            PH_EXTRA_LO:
            begin
                if (item.start_button)
                begin
                    go_abort = 1'b1;
                end
                else
                begin
                    timer_next = timer_dec;
                    if (timer_done)
                    begin
                        pulses_next = (pulses_reg != 4'd0) ? pulses_reg - 4'd1 : 4'd0;
                        if (pulses_next != 4'd0)
                        begin
                            phase_next = PH_EXTRA_HI;
                            timer_next = step_len;
                        end
                        else
                        begin
                            go_top = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                go_abort = 1'b1;
            end
        endcase

        if (go_top)
        begin
            if (item.start_button)
            begin
                go_abort = 1'b1;
            end
            else if (!latched_next)
            begin
                drive_off_next = 1'b0;
                phase_next     = PH_SEEK_HI;
                timer_next     = step_len;
            end
            else
            begin
                go_stamp = 1'b1;
            end
        end

        if (go_stamp)
        begin
            if (item.start_button)
            begin
                go_abort = 1'b1;
            end
            else
            begin
                piece_next  = item.piece_sensor;
                pulses_next = item.piece_sensor ? STAMPS_WITH_PIECE : STAMPS_NO_PIECE;
                if (!item.piece_sensor)
                begin
                    drive_off_next = 1'b1;
                end
                phase_next = PH_STAMP_ON;
                timer_next = pulse_len;
            end
        end

        if (go_abort)
        begin
            armed_next = 1'b0;
            go_idle    = 1'b1;
        end

        if (go_idle)
        begin
            phase_next     = PH_IDLE;
            timer_next     = '0;
            drive_off_next = 1'b1;
            shown_next     = STATUS_PROMPT;
            latched_next   = item.cradle_sensor;
            if (item.start_button)
            begin
                armed_next = arms_reg;
                arms_next  = !arms_reg;
                shown_next = arms_reg ? STATUS_STARTING : STATUS_LOCKED;
                phase_next = PH_ANNOUNCE;
                timer_next = announce_len;
            end
        end
    end

    always_comb
    begin
        result.step_pulse     = (phase_next == PH_SEEK_HI) || (phase_next == PH_PASS_HI) ||
                                (phase_next == PH_LEAVE_HI) || (phase_next == PH_EXTRA_HI);
        result.driver_disable = drive_off_next;
        result.stamp_out      = (phase_next == PH_STAMP_ON);
        result.piece_count    = 16'(total_next);
        result.display_status = shown_next;
    end

endmodule
